### hdl/cft_pkg.sv
// shared types and constants for the csv field tokenizer
`default_nettype none

package cft_pkg;

   // parser modes
   typedef enum logic [2:0] {
      MODE_PLAIN  = 3'd0,
      MODE_QUOTED = 3'd1,
      MODE_DBLQ   = 3'd2,
      MODE_ESCAPE = 3'd3,
      MODE_CLOSED = 3'd4,
      MODE_ERROR  = 3'd5
   } mode_type;

   // input opcodes
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_SEP   = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_QUOTE_MID   = 2'd1;
   localparam logic [1:0] ERR_BAD_AFTER_Q = 2'd2;
   localparam logic [1:0] ERR_TEXT_AFTER  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_SEPARATOR = 2'd0;
   localparam logic [1:0] CSR_QUOTE     = 2'd1;
   localparam logic [1:0] CSR_ESCAPE    = 2'd2;

   localparam logic [7:0] SEPARATOR_RESET = 8'd44;
   localparam logic [7:0] QUOTE_RESET     = 8'd34;
   localparam logic [7:0] ESCAPE_RESET    = 8'd34;
   localparam logic [7:0] NUL_BYTE        = 8'd0;

   typedef struct packed {
      logic [7:0] separator_byte;
      logic [7:0] quote_byte;
      logic [7:0] escape_byte;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] result_kind;
      logic [7:0] field_byte;
      logic [1:0] error_code;
   } result_type;

endpackage

`default_nettype wire

### hdl/csv_field_tokenizer_top.sv
// top level of the csv field tokenizer: registers, input and result stages
//
// usage
//   req channel: one transfer per byte (req_opcode 0, req_byte_value) or an
//   end-of-buffer marker (req_opcode 1). rsp channel: at most one result per
//   transfer in: field byte, field end (separator or end of buffer) or error.
//   csr port: write separator (index 0), quote (1) and escape (2) while idle.
// timing
//   an accepted item sits in the input register and is parsed on the way into
//   the result register, from which its result shows on rsp. one item per
//   cycle sustained while rsp_ready stays high; the parser state update in the
//   single input-to-result stage is the only loop.
// reset
//   synchronous; registers return to comma, double quote, double quote; the
//   parser returns to the start of a buffer with both stages empty.
// stalls
//   while rsp_ready is low and a result is held, nothing leaves the input
//   register; it takes one more transfer if empty, then req_ready stays low
//   until the held result is taken.
`default_nettype none

module csv_field_tokenizer_top (
   input  wire        clock,
   input  wire        reset,
   // config write port
   input  wire        csr_write_enable,
   input  wire  [1:0] csr_index,
   input  wire  [7:0] csr_write_data,
   // input channel
   input  wire        req_valid,
   output logic       req_ready,
   input  wire        req_opcode,
   input  wire  [7:0] req_byte_value,
   // result channel
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_field_byte,
   output logic [1:0] rsp_error_code
);

   cft_pkg::cfg_type    cfg_ff;
   cft_pkg::result_type parse_result;

   logic       in_valid_ff;
   logic       in_opcode_ff;
   logic [7:0] in_byte_ff;

   logic       out_valid_ff;
   logic [1:0] out_kind_ff;
   logic [7:0] out_byte_ff;
   logic [1:0] out_err_ff;

   logic out_free;
   logic step;

   // config registers, unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.separator_byte <= cft_pkg::SEPARATOR_RESET;
         cfg_ff.quote_byte     <= cft_pkg::QUOTE_RESET;
         cfg_ff.escape_byte    <= cft_pkg::ESCAPE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            cft_pkg::CSR_SEPARATOR: cfg_ff.separator_byte <= csr_write_data;
            cft_pkg::CSR_QUOTE:     cfg_ff.quote_byte     <= csr_write_data;
            cft_pkg::CSR_ESCAPE:    cfg_ff.escape_byte    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // result register is free when empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   // held item moves through the parser when its result has somewhere to go
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_opcode_ff <= req_opcode;
         in_byte_ff   <= req_byte_value;
      end
   end

   cft_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .opcode     (in_opcode_ff),
      .byte_value (in_byte_ff),
      .cfg        (cfg_ff),
      .result     (parse_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && parse_result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step && parse_result.valid) begin
         out_kind_ff <= parse_result.result_kind;
         out_byte_ff <= parse_result.field_byte;
         out_err_ff  <= parse_result.error_code;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_field_byte  = out_byte_ff;
   assign rsp_error_code  = out_err_ff;

endmodule

`default_nettype wire

### hdl/cft_parse.sv
// parser state and next-state logic, one item per step
`default_nettype none

module cft_parse (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      step,
   input  wire                      opcode,
   input  wire  [7:0]               byte_value,
   input  wire  cft_pkg::cfg_type   cfg,
   output cft_pkg::result_type      result
);

   cft_pkg::mode_type mode_ff, mode_in;
   logic              field_started_ff, field_started_in;
   logic              at_buffer_start_ff, at_buffer_start_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= cft_pkg::MODE_PLAIN;
         field_started_ff   <= 1'b0;
         at_buffer_start_ff <= 1'b1;
      end else if (step) begin
         mode_ff            <= mode_in;
         field_started_ff   <= field_started_in;
         at_buffer_start_ff <= at_buffer_start_in;
      end
   end

   always_comb begin
      logic is_sep;
      logic is_quote;
      logic is_escape;
      logic dbl_mode;

      is_sep    = (byte_value == cfg.separator_byte) || (byte_value == cft_pkg::NUL_BYTE);
      is_quote  = (byte_value == cfg.quote_byte);
      is_escape = (byte_value == cfg.escape_byte);
      dbl_mode  = (cfg.quote_byte == cfg.escape_byte);

      mode_in            = mode_ff;
      field_started_in   = field_started_ff;
      at_buffer_start_in = at_buffer_start_ff;
      result.valid       = 1'b0;
      result.result_kind = cft_pkg::KIND_BYTE;
      result.field_byte  = 8'd0;
      result.error_code  = cft_pkg::ERR_NONE;

      if (opcode == cft_pkg::OP_END) begin
         mode_in            = cft_pkg::MODE_PLAIN;
         field_started_in   = 1'b0;
         at_buffer_start_in = 1'b1;
         if (mode_ff != cft_pkg::MODE_ERROR) begin
            result.valid       = 1'b1;
            result.result_kind = cft_pkg::KIND_END;
         end
      end else if (at_buffer_start_ff && is_sep) begin
         // leading separator of a buffer is dropped
         at_buffer_start_in = 1'b0;
      end else begin
         at_buffer_start_in = 1'b0;
         case (mode_ff)
            cft_pkg::MODE_PLAIN: begin
               if (is_quote) begin
                  if (field_started_ff) begin
                     mode_in            = cft_pkg::MODE_ERROR;
                     result.valid       = 1'b1;
                     result.result_kind = cft_pkg::KIND_ERROR;
                     result.error_code  = cft_pkg::ERR_QUOTE_MID;
                  end else begin
                     mode_in = cft_pkg::MODE_QUOTED;
                  end
               end else if (is_sep) begin
                  field_started_in   = 1'b0;
                  result.valid       = 1'b1;
                  result.result_kind = cft_pkg::KIND_SEP;
               end else begin
                  field_started_in  = 1'b1;
                  result.valid      = 1'b1;
                  result.field_byte = byte_value;
               end
            end
            cft_pkg::MODE_QUOTED: begin
               if (dbl_mode && is_quote) begin
                  mode_in = cft_pkg::MODE_DBLQ;
               end else if (!dbl_mode && is_escape) begin
                  mode_in = cft_pkg::MODE_ESCAPE;
               end else if (!dbl_mode && is_quote) begin
                  mode_in = cft_pkg::MODE_CLOSED;
               end else begin
                  result.valid      = 1'b1;
                  result.field_byte = byte_value;
               end
            end
            cft_pkg::MODE_DBLQ: begin
               if (is_quote) begin
                  // doubled quote stands for one quote
                  mode_in           = cft_pkg::MODE_QUOTED;
                  result.valid      = 1'b1;
                  result.field_byte = byte_value;
               end else if (is_sep) begin
                  mode_in            = cft_pkg::MODE_PLAIN;
                  field_started_in   = 1'b0;
                  result.valid       = 1'b1;
                  result.result_kind = cft_pkg::KIND_SEP;
               end else begin
                  mode_in            = cft_pkg::MODE_ERROR;
                  result.valid       = 1'b1;
                  result.result_kind = cft_pkg::KIND_ERROR;
                  result.error_code  = cft_pkg::ERR_BAD_AFTER_Q;
               end
            end
            cft_pkg::MODE_ESCAPE: begin
               mode_in           = cft_pkg::MODE_QUOTED;
               result.valid      = 1'b1;
               result.field_byte = byte_value;
            end
            cft_pkg::MODE_CLOSED: begin
               if (is_sep) begin
                  mode_in            = cft_pkg::MODE_PLAIN;
                  field_started_in   = 1'b0;
                  result.valid       = 1'b1;
                  result.result_kind = cft_pkg::KIND_SEP;
               end else begin
                  mode_in            = cft_pkg::MODE_ERROR;
                  result.valid       = 1'b1;
                  result.result_kind = cft_pkg::KIND_ERROR;
                  result.error_code  = cft_pkg::ERR_TEXT_AFTER;
               end
            end
            default: begin
               // error mode drops data until end of buffer
               mode_in = cft_pkg::MODE_ERROR;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### dv/csv_field_tokenizer_top_tb.sv
// self-checking testbench for the csv field tokenizer: csv lines, noise and register settings
`default_nettype none

module csv_field_tokenizer_top_tb;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 215;
   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [1:0] code;
   } token_type;

   // mirrors the parser and holds the tokens still owed by the block
   class field_token_checker;
      logic [7:0]        separator;
      logic [7:0]        quote;
      logic [7:0]        escape;
      cft_pkg::mode_type mode;
      bit                field_started;
      bit                at_buffer_start;
      token_type         expected_tokens[$];
      int                fail_count;

      function new();
         separator       = cft_pkg::SEPARATOR_RESET;
         quote           = cft_pkg::QUOTE_RESET;
         escape          = cft_pkg::ESCAPE_RESET;
         mode            = cft_pkg::MODE_PLAIN;
         field_started   = 1'b0;
         at_buffer_start = 1'b1;
         fail_count      = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [7:0] value);
         case (index)
            cft_pkg::CSR_SEPARATOR: separator = value;
            cft_pkg::CSR_QUOTE:     quote = value;
            cft_pkg::CSR_ESCAPE:    escape = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      function bit is_separator(logic [7:0] c);
         return c == separator || c == cft_pkg::NUL_BYTE;
      endfunction

      function void owe(logic [1:0] kind, logic [7:0] value, logic [1:0] code);
         token_type t;
         t.kind  = kind;
         t.value = value;
         t.code  = code;
         expected_tokens.push_back(t);
      endfunction

      function void close_field(logic [1:0] kind);
         mode          = cft_pkg::MODE_PLAIN;
         field_started = 1'b0;
         owe(kind, 8'd0, cft_pkg::ERR_NONE);
      endfunction

      function void raise_error(logic [1:0] code);
         mode = cft_pkg::MODE_ERROR;
         owe(cft_pkg::KIND_ERROR, 8'd0, code);
      endfunction

      function void take_input(logic op, logic [7:0] c);
         bit was_error;
         if (op == cft_pkg::OP_END) begin
            was_error       = (mode == cft_pkg::MODE_ERROR);
            mode            = cft_pkg::MODE_PLAIN;
            field_started   = 1'b0;
            at_buffer_start = 1'b1;
            if (!was_error) owe(cft_pkg::KIND_END, 8'd0, cft_pkg::ERR_NONE);
            return;
         end
         // leading separator of a buffer is dropped before any quote test
         if (at_buffer_start) begin
            at_buffer_start = 1'b0;
            if (is_separator(c)) return;
         end
         case (mode)
            cft_pkg::MODE_PLAIN: begin
               if (c == quote) begin
                  if (field_started) raise_error(cft_pkg::ERR_QUOTE_MID);
                  else mode = cft_pkg::MODE_QUOTED;
               end else if (is_separator(c)) begin
                  close_field(cft_pkg::KIND_SEP);
               end else begin
                  field_started = 1'b1;
                  owe(cft_pkg::KIND_BYTE, c, cft_pkg::ERR_NONE);
               end
            end
            cft_pkg::MODE_QUOTED: begin
               if (quote == escape) begin
                  if (c == quote) mode = cft_pkg::MODE_DBLQ;
                  else owe(cft_pkg::KIND_BYTE, c, cft_pkg::ERR_NONE);
               end else if (c == escape) begin
                  mode = cft_pkg::MODE_ESCAPE;
               end else if (c == quote) begin
                  mode = cft_pkg::MODE_CLOSED;
               end else begin
                  owe(cft_pkg::KIND_BYTE, c, cft_pkg::ERR_NONE);
               end
            end
            cft_pkg::MODE_DBLQ: begin
               if (c == quote) begin
                  mode = cft_pkg::MODE_QUOTED;
                  owe(cft_pkg::KIND_BYTE, c, cft_pkg::ERR_NONE);
               end else if (is_separator(c)) begin
                  close_field(cft_pkg::KIND_SEP);
               end else begin
                  raise_error(cft_pkg::ERR_BAD_AFTER_Q);
               end
            end
            cft_pkg::MODE_ESCAPE: begin
               mode = cft_pkg::MODE_QUOTED;
               owe(cft_pkg::KIND_BYTE, c, cft_pkg::ERR_NONE);
            end
            cft_pkg::MODE_CLOSED: begin
               if (is_separator(c)) close_field(cft_pkg::KIND_SEP);
               else raise_error(cft_pkg::ERR_TEXT_AFTER);
            end
            default: mode = cft_pkg::MODE_ERROR;
         endcase
      endfunction

      function void check_token(logic [1:0] kind, logic [7:0] value, logic [1:0] code);
         token_type t;
         if (expected_tokens.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected token: kind %0d byte %02h err %0d", kind, value, code);
            return;
         end
         t = expected_tokens.pop_front();
         if (kind !== t.kind || value !== t.value || code !== t.code) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("token mismatch (exp/got): kind %0d/%0d byte %02h/%02h err %0d/%0d",
                        t.kind, kind, t.value, value, t.code, code);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_index = cft_pkg::CSR_SEPARATOR;
   logic [7:0] csr_write_data = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_opcode = cft_pkg::OP_DATA;
   logic [7:0] req_byte_value = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_field_byte;
   logic [1:0] rsp_error_code;

   field_token_checker sb = new();
   int burst_left = 0;
   int sent_count = 0;
   int cycle_count = 0;
   int ready_run = 0;
   int ready_stall = 0;

   csv_field_tokenizer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_field_byte   (rsp_field_byte),
      .rsp_error_code   (rsp_error_code)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // result side: short stalls most of the time, now and then long ones or long open runs
   always @(negedge clock) begin
      if (ready_stall > 0) begin
         rsp_ready = 1'b0;
         ready_stall--;
      end else begin
         rsp_ready = 1'b1;
         if (ready_run > 0) begin
            ready_run--;
         end else begin
            ready_run   = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 8);
            ready_stall = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 16)
                                                      : $urandom_range(0, 3);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_token(rsp_result_kind, rsp_field_byte, rsp_error_code);
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic op, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) req_valid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid      = 1'b1;
      req_opcode     = op;
      req_byte_value = b;
      do @(posedge clock); while (!req_ready);
      sb.take_input(op, b);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = value;
      sb.set_register(index, value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_delimiters(input logic [7:0] s, input logic [7:0] q, input logic [7:0] e);
      write_register(cft_pkg::CSR_SEPARATOR, s);
      write_register(cft_pkg::CSR_QUOTE, q);
      write_register(cft_pkg::CSR_ESCAPE, e);
   endtask

   // block drained; extra cycles cover items still inside that give no token
   task automatic wait_idle();
      req_valid  = 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // random byte leaning toward the delimiter bytes and the extremes
   function automatic logic [7:0] any_byte();
      case ($urandom_range(0, 19))
         0:       return sb.separator;
         1:       return sb.quote;
         2:       return sb.escape;
         3:       return cft_pkg::NUL_BYTE;
         4:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = any_byte();
      while (b == sb.separator || b == cft_pkg::NUL_BYTE || b == sb.quote);
      return b;
   endfunction

   // one well-formed line of plain and quoted fields, sometimes cut short
   task automatic send_csv_line();
      int         n_fields;
      int         len;
      logic [7:0] b;
      n_fields = $urandom_range(1, 5);
      if ($urandom_range(0, 7) == 0)
         send_item(cft_pkg::OP_DATA,
                   ($urandom_range(0, 1) == 0) ? sb.separator : cft_pkg::NUL_BYTE);
      for (int f = 0; f < n_fields; f++) begin
         len = $urandom_range(0, 6);
         if ($urandom_range(0, 2) == 0) begin
            send_item(cft_pkg::OP_DATA, sb.quote);
            for (int i = 0; i < len; i++) begin
               b = any_byte();
               // doubled quote or escape prefix keeps the byte literal
               if (b == sb.quote || b == sb.escape)
                  send_item(cft_pkg::OP_DATA,
                            (sb.quote == sb.escape) ? sb.quote : sb.escape);
               send_item(cft_pkg::OP_DATA, b);
            end
            if ($urandom_range(0, 15) == 0) begin
               // unclosed quoted field, or a dangling escape, runs into end of buffer
               if (sb.quote != sb.escape && $urandom_range(0, 1) == 0)
                  send_item(cft_pkg::OP_DATA, sb.escape);
               send_item(cft_pkg::OP_END, 8'($urandom_range(0, 255)));
               return;
            end
            send_item(cft_pkg::OP_DATA, sb.quote);
         end else begin
            for (int i = 0; i < len; i++) send_item(cft_pkg::OP_DATA, plain_byte());
         end
         if (f < n_fields - 1)
            send_item(cft_pkg::OP_DATA,
                      ($urandom_range(0, 3) == 0) ? cft_pkg::NUL_BYTE : sb.separator);
      end
      if ($urandom_range(0, 5) == 0) send_item(cft_pkg::OP_DATA, sb.separator);
      send_item(cft_pkg::OP_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 14);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(cft_pkg::OP_END, 8'($urandom_range(0, 255)));
         else
            send_item(cft_pkg::OP_DATA, any_byte());
      end
      send_item(cft_pkg::OP_END, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int start_count;
      logic [7:0] s;
      logic [7:0] q;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset delimiters: comma, double quote, double quote
      send_item(cft_pkg::OP_END, 8'h00);          // empty buffer gives one empty field
      send_item(cft_pkg::OP_DATA, 8'h2C);         // leading separator dropped
      send_item(cft_pkg::OP_DATA, 8'h61);
      send_item(cft_pkg::OP_DATA, 8'hFF);
      send_item(cft_pkg::OP_DATA, 8'h22);         // quote in mid-field
      send_item(cft_pkg::OP_DATA, 8'h7A);         // dropped while in error
      send_item(cft_pkg::OP_END, 8'hFF);          // silent end after error
      send_item(cft_pkg::OP_DATA, cft_pkg::NUL_BYTE); // leading nul dropped
      send_item(cft_pkg::OP_DATA, 8'h22);
      send_item(cft_pkg::OP_DATA, 8'h78);
      send_item(cft_pkg::OP_DATA, 8'h22);
      send_item(cft_pkg::OP_DATA, 8'h22);         // doubled quote gives one quote
      send_item(cft_pkg::OP_DATA, 8'h22);
      send_item(cft_pkg::OP_DATA, 8'h2C);
      send_item(cft_pkg::OP_DATA, 8'h2C);         // empty field
      send_item(cft_pkg::OP_END, 8'h00);
      send_item(cft_pkg::OP_DATA, 8'h22);
      send_item(cft_pkg::OP_DATA, 8'h71);
      send_item(cft_pkg::OP_DATA, 8'h22);
      send_item(cft_pkg::OP_DATA, 8'h6B);         // bad byte after closing quote
      send_item(cft_pkg::OP_END, 8'h00);
      wait_idle();

      // distinct escape byte: escaped quote, then text after the closing quote
      write_register(cft_pkg::CSR_ESCAPE, 8'h5C);
      send_item(cft_pkg::OP_DATA, 8'h22);
      send_item(cft_pkg::OP_DATA, 8'h5C);
      send_item(cft_pkg::OP_DATA, 8'h22);
      send_item(cft_pkg::OP_DATA, 8'h22);
      send_item(cft_pkg::OP_DATA, 8'h78);
      send_item(cft_pkg::OP_END, 8'h00);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         s = 8'($urandom_range(0, 255));
         q = 8'($urandom_range(0, 255));
         case (p)
            0: set_delimiters(cft_pkg::SEPARATOR_RESET, cft_pkg::QUOTE_RESET,
                              cft_pkg::ESCAPE_RESET);
            1: set_delimiters(8'h00, 8'hFF, 8'hFF);
            2: set_delimiters(8'hFF, 8'h00, 8'h01);
            3: set_delimiters(8'h3B, 8'h27, 8'h5C);
            4: set_delimiters(s, q, 8'($urandom_range(0, 255)));
            5: set_delimiters(s, q, q);
            6: set_delimiters(s, s, 8'($urandom_range(0, 255)));
            default: set_delimiters(s, q, s);
         endcase
         start_count = sent_count;
         while (sent_count - start_count < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_csv_line();
         end
         wait_idle();
      end

      if (sb.pending() != 0)
         $display("%0d expected tokens never arrived", sb.pending());
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

### csv_field_tokenizer_top.f
hdl/cft_pkg.sv
hdl/cft_parse.sv
hdl/csv_field_tokenizer_top.sv
dv/csv_field_tokenizer_top_tb.sv
